// ----- hw/rtl/tpsq_pkg.sv -----
// Shared types and constants for the touch point sample qualifier
package tpsq_pkg;

    // adc sample width and largest reading
    localparam int ADC_W   = 12;
    localparam int ADC_MAX = 4095;

    // packed stream payload widths
    localparam int DATA_W  = 24;
    localparam int S_USER_W = 1;
    localparam int M_USER_W = 2;

    // stability limit after reset, in adc counts
    localparam int LIMIT_RST = 50;

    // request kinds on the input stream
    typedef enum logic [S_USER_W-1:0] {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [M_USER_W-1:0] {
        ST_COLLECT  = 2'd0,
        ST_ACCEPT   = 2'd1,
        ST_UNSTABLE = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

endpackage

// ----- hw/rtl/touch_point_sample_qualifier.sv -----
// Touch point sample qualifier: running sums, spread test and rounded means
// Requests pass through the input stage, the processing stage and the result register.
// Throughput: one request per cycle while the result side accepts; the running sums and
// the incremental spread term update through one sum-by-sample multiplier per axis.
// Reset (synchronous, active low) clears the count, sums, pipeline valids and
// sets the stability limit to 50; no clearing pass is needed.
module touch_point_sample_qualifier #(
    parameter int SAMPLES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: stability_limit
    input  logic                           i_cfg_we,
    input  logic [tpsq_pkg::ADC_W-1:0]     i_cfg_wdata,
    // input requests
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: adc_x [11:0], adc_y [23:12]
    input  logic [tpsq_pkg::DATA_W-1:0]    s_axis_tdata,
    // tuser: op [0]
    input  logic [tpsq_pkg::S_USER_W-1:0]  s_axis_tuser,
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: mean_x [11:0], mean_y [23:12]
    output logic [tpsq_pkg::DATA_W-1:0]    m_axis_tdata,
    // tuser: status [1:0]
    output logic [tpsq_pkg::M_USER_W-1:0]  m_axis_tuser
);
    import tpsq_pkg::*;

    // widths that follow from the sample count
    localparam int CW = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;
    localparam int SW = $clog2(SAMPLES * ADC_MAX + 1);
    localparam logic [63:0] D_MAX =
        64'(SAMPLES) * 64'(SAMPLES) * 64'(ADC_MAX * ADC_MAX);
    localparam int DW = $clog2(D_MAX + 64'd1);
    localparam int NN1 = SAMPLES * (SAMPLES - 1);
    localparam logic [63:0] B_MAX = 64'(ADC_MAX * ADC_MAX) * 64'(NN1);
    localparam int BW = $clog2(B_MAX + 64'd1);
    localparam logic [BW-1:0] BOUND_RST = BW'(LIMIT_RST * LIMIT_RST * NN1);
    localparam logic [CW-1:0] LAST_CNT = CW'(SAMPLES - 1);

    // rounded mean as floor((2*sum + N) / (2*N)) by reciprocal multiply
    localparam int VW = $clog2(SAMPLES * (2 * ADC_MAX + 1) + 1);
    localparam int DIV = 2 * SAMPLES;
    localparam int SH = VW + $clog2(DIV);
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam int MW = $clog2(RECIP + 64'd1);
    localparam int PW = VW + MW;

    // handshake and stage flow
    logic r_a_valid, r_b_valid, r_o_valid;
    logic w_o_free, w_b_free, w_a_free, w_b_mv, w_a_mv, w_in_acc;

    assign w_o_free = !r_o_valid || m_axis_tready;
    assign w_b_free = !r_b_valid || w_o_free;
    assign w_b_mv   = r_b_valid && w_o_free;
    assign w_a_free = !r_a_valid || w_b_free;
    assign w_a_mv   = r_a_valid && w_b_free;
    assign w_in_acc = s_axis_tvalid && w_a_free;
    assign s_axis_tready = w_a_free;

    // stability bound register: limit^2 * N * (N-1)
    logic [BW-1:0]      r_bound;
    logic [2*ADC_W-1:0] w_lim_sq;

    assign w_lim_sq = i_cfg_wdata * i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= BOUND_RST;
        end else if (i_cfg_we) begin
            r_bound <= BW'(w_lim_sq * NN1);
        end
    end

    // input stage: sample squares scaled by N-1
    t_op                r_a_op;
    logic [ADC_W-1:0]   r_a_x, r_a_y;
    logic [DW-1:0]      r_a_qx, r_a_qy;
    logic [ADC_W-1:0]   w_in_x, w_in_y;
    logic [2*ADC_W-1:0] w_sq_x, w_sq_y;

    assign w_in_x = s_axis_tdata[ADC_W-1:0];
    assign w_in_y = s_axis_tdata[2*ADC_W-1:ADC_W];
    assign w_sq_x = w_in_x * w_in_x;
    assign w_sq_y = w_in_y * w_in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (w_in_acc) begin
            r_a_op <= t_op'(s_axis_tuser[0]);
            r_a_x  <= w_in_x;
            r_a_y  <= w_in_y;
            r_a_qx <= DW'(w_sq_x * (SAMPLES - 1));
            r_a_qy <= DW'(w_sq_y * (SAMPLES - 1));
        end
    end

    // accumulator state; spread term d = N*sumsq - sum^2 kept incrementally
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [SW-1:0] r_sum_x, r_sum_y, n_sum_x, n_sum_y;
    logic [DW-1:0] r_d_x, r_d_y, n_d_x, n_d_y;

    // processing stage registers
    logic          r_b_final;
    t_status       r_b_status;
    logic [SW-1:0] r_b_sx, r_b_sy;
    logic [DW-1:0] r_b_dx, r_b_dy;

    logic             w_b_stable, w_done_eff, w_final;
    logic [SW+ADC_W-1:0] w_prod_x, w_prod_y;
    logic [DW-1:0]    w_dn_x, w_dn_y;
    logic [SW-1:0]    w_sn_x, w_sn_y;
    t_status          n_b_status;

    // verdict of a completed point waiting in the processing stage
    assign w_b_stable = !(r_b_dx > DW'(r_bound)) && !(r_b_dy > DW'(r_bound));
    assign w_done_eff = r_done || (r_b_valid && r_b_final && w_b_stable);

    // d grows by (N-1)*x^2 - 2*sum*x for each sample
    assign w_prod_x = r_sum_x * r_a_x;
    assign w_prod_y = r_sum_y * r_a_y;
    assign w_dn_x = r_d_x + r_a_qx - DW'({w_prod_x, 1'b0});
    assign w_dn_y = r_d_y + r_a_qy - DW'({w_prod_y, 1'b0});
    assign w_sn_x = r_sum_x + SW'(r_a_x);
    assign w_sn_y = r_sum_y + SW'(r_a_y);
    assign w_final = (r_cnt == LAST_CNT);

    // next state for an item leaving the input stage or a point leaving the processing stage
    always_comb begin
        n_cnt      = r_cnt;
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_d_x      = r_d_x;
        n_d_y      = r_d_y;
        n_done     = r_done;
        n_b_status = ST_COLLECT;
        if (w_b_mv && r_b_final) begin
            n_done = w_b_stable;
        end
        if (w_a_mv) begin
            case (r_a_op)
                OP_CLEAR: begin
                    n_cnt   = '0;
                    n_sum_x = '0;
                    n_sum_y = '0;
                    n_d_x   = '0;
                    n_d_y   = '0;
                    n_done  = 1'b0;
                end
                OP_SAMPLE: begin
                    if (w_done_eff) begin
                        n_b_status = ST_IGNORED;
                    end else if (w_final) begin
                        // point resolves downstream, sums restart either way
                        n_cnt   = '0;
                        n_sum_x = '0;
                        n_sum_y = '0;
                        n_d_x   = '0;
                        n_d_y   = '0;
                    end else begin
                        n_cnt   = CW'(r_cnt + 1'b1);
                        n_sum_x = w_sn_x;
                        n_sum_y = w_sn_y;
                        n_d_x   = w_dn_x;
                        n_d_y   = w_dn_y;
                    end
                end
                default: begin
                    n_b_status = ST_COLLECT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_done    <= 1'b0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_d_x     <= '0;
            r_d_y     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_d_x   <= n_d_x;
            r_d_y   <= n_d_y;
            if (w_b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
        if (w_a_mv) begin
            r_b_status <= n_b_status;
            r_b_final  <= (r_a_op == OP_SAMPLE) && !w_done_eff && w_final;
            r_b_sx     <= w_sn_x;
            r_b_sy     <= w_sn_y;
            r_b_dx     <= w_dn_x;
            r_b_dy     <= w_dn_y;
        end
    end

    // rounded means of a completed point
    logic [VW-1:0]    w_vx, w_vy;
    logic [PW-1:0]    w_px, w_py;
    logic [ADC_W-1:0] w_mean_x, w_mean_y;

    assign w_vx = VW'({r_b_sx, 1'b0}) + VW'(SAMPLES);
    assign w_vy = VW'({r_b_sy, 1'b0}) + VW'(SAMPLES);
    assign w_px = w_vx * RECIP[MW-1:0];
    assign w_py = w_vy * RECIP[MW-1:0];
    assign w_mean_x = ADC_W'(w_px >> SH);
    assign w_mean_y = ADC_W'(w_py >> SH);

    // result register
    t_status          r_o_status;
    logic [ADC_W-1:0] r_o_mx, r_o_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_free) begin
            r_o_valid <= r_b_valid;
        end
        if (w_b_mv) begin
            if (r_b_final && w_b_stable) begin
                r_o_status <= ST_ACCEPT;
                r_o_mx     <= w_mean_x;
                r_o_my     <= w_mean_y;
            end else begin
                r_o_status <= r_b_final ? ST_UNSTABLE : r_b_status;
                r_o_mx     <= '0;
                r_o_my     <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_my, r_o_mx};
    assign m_axis_tuser  = r_o_status;

endmodule

// ----- tb/sv/touch_point_sample_qualifier_test.sv -----
// Testbench for the touch point sample qualifier: predicted point results checked on the stream
module touch_point_sample_qualifier_test;
    import tpsq_pkg::*;

    localparam int SAMPLES      = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // one expected result as it leaves the block
    typedef struct packed {
        t_status          status;
        logic [ADC_W-1:0] mean_x;
        logic [ADC_W-1:0] mean_y;
    } t_point_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [ADC_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic [S_USER_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [M_USER_W-1:0]   m_axis_tuser;

    // predicted point state
    logic [4:0]            pt_count;
    logic [15:0]           pt_sum_x;
    logic [15:0]           pt_sum_y;
    logic [27:0]           pt_sq_x;
    logic [27:0]           pt_sq_y;
    logic [ADC_W-1:0]      pt_limit;

    t_point_result         pending_results[$];
    int                    errors = 0;
    int                    sent_count = 0;
    int                    idle_cycles = 0;
    bit                    steady_flow = 1'b0;
    bit                    hold_off_req = 1'b0;

    touch_point_sample_qualifier #(
        .SAMPLES(SAMPLES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void clear_point();
        pt_count = '0;
        pt_sum_x = '0;
        pt_sum_y = '0;
        pt_sq_x  = '0;
        pt_sq_y  = '0;
    endfunction

    // exact integer form of the sample deviation test
    function automatic bit spread_too_wide(logic [15:0] sum, logic [27:0] sumsq,
                                           logic [ADC_W-1:0] lim);
        logic [63:0] lhs;
        logic [63:0] sum_sq;
        logic [63:0] bound;
        lhs    = sumsq;
        lhs    = lhs * SAMPLES;
        sum_sq = sum;
        sum_sq = sum_sq * sum_sq;
        bound  = lim;
        bound  = bound * bound * (SAMPLES * (SAMPLES - 1));
        return lhs > sum_sq + bound;
    endfunction

    // mean rounded half up
    function automatic logic [ADC_W-1:0] rounded_mean(logic [15:0] sum);
        logic [31:0] twice;
        twice = sum;
        twice = 2 * twice + SAMPLES;
        return ADC_W'(twice / (2 * SAMPLES));
    endfunction

    // advance the predicted state by one accepted request
    function automatic t_point_result predict_request(t_op op, logic [ADC_W-1:0] x,
                                                      logic [ADC_W-1:0] y);
        t_point_result r;
        r.status = ST_COLLECT;
        r.mean_x = '0;
        r.mean_y = '0;
        if (op == OP_CLEAR) begin
            clear_point();
            return r;
        end
        if (pt_count >= SAMPLES) begin
            r.status = ST_IGNORED;
            return r;
        end
        pt_sum_x = pt_sum_x + x;
        pt_sum_y = pt_sum_y + y;
        pt_sq_x  = pt_sq_x + 28'(x) * 28'(x);
        pt_sq_y  = pt_sq_y + 28'(y) * 28'(y);
        pt_count = pt_count + 1'b1;
        if (pt_count < SAMPLES)
            return r;
        if (spread_too_wide(pt_sum_x, pt_sq_x, pt_limit) ||
            spread_too_wide(pt_sum_y, pt_sq_y, pt_limit)) begin
            clear_point();
            r.status = ST_UNSTABLE;
        end else begin
            r.status = ST_ACCEPT;
            r.mean_x = rounded_mean(pt_sum_x);
            r.mean_y = rounded_mean(pt_sum_y);
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [ADC_W-1:0] jitter(int center, int spread);
        int v;
        v = center - spread + $urandom_range(0, 2 * spread);
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return ADC_W'(v);
    endfunction

    function automatic int pick_center();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return ADC_MAX;
        return $urandom_range(0, ADC_MAX);
    endfunction

    function automatic int pick_spread(int lim);
        int s;
        case ($urandom_range(0, 4))
            0: s = 0;
            1: s = lim;
            2: s = 2 * lim;
            3: s = (3 * lim) / 2;
            default: s = $urandom_range(0, ADC_MAX);
        endcase
        return (s > ADC_MAX) ? ADC_MAX : s;
    endfunction

    // offset sample that sits 4*limit (plus 0 or 1) away from the rest
    function automatic logic [ADC_W-1:0] edge_sample(int center, int lim);
        int dev;
        dev = 4 * lim + $urandom_range(0, 1);
        if (center + dev <= ADC_MAX)
            return ADC_W'(center + dev);
        if (center - dev >= 0)
            return ADC_W'(center - dev);
        return (center < ADC_MAX / 2) ? ADC_W'(ADC_MAX) : '0;
    endfunction

    // send one request and record its expected result when accepted
    task automatic send_request(t_op op, logic [ADC_W-1:0] x, logic [ADC_W-1:0] y);
        int gap;
        t_point_result r;
        gap = steady_flow ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = predict_request(op, x, y);
        pending_results.push_back(r);
        if (r.status != ST_IGNORED)
            sent_count++;
    endtask

    // limit write once every pending result has drained
    task automatic write_limit(logic [ADC_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        pt_limit = value;
        i_cfg_we <= 1'b0;
    endtask

    // reset limit: fifteen equal samples and one 4*limit away give exactly the limit
    task automatic test_limit_edge();
        repeat (SAMPLES - 1)
            send_request(OP_SAMPLE, 12'd1000, 12'd3000);
        send_request(OP_SAMPLE, ADC_W'(1000 + 4 * LIMIT_RST), ADC_W'(3000 - 4 * LIMIT_RST));
        // point complete, so this sample is ignored
        send_request(OP_SAMPLE, 12'd7, 12'd9);
        send_request(OP_CLEAR, 12'd5, 12'd6);
    endtask

    // readings at both ends of the range, clear with nonzero data
    task automatic test_field_extremes();
        send_request(OP_SAMPLE, '0, ADC_W'(ADC_MAX));
        send_request(OP_SAMPLE, ADC_W'(ADC_MAX), '0);
        send_request(OP_SAMPLE, ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_CLEAR, ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
    endtask

    // mostly complete points with random content, some noise and cut-off points
    task automatic test_random_points(logic [ADC_W-1:0] lim, int items);
        int goal;
        int kind;
        int cx;
        int cy;
        int sx;
        int sy;
        int odd;
        goal = sent_count + items;
        write_limit(lim);
        while (sent_count < goal) begin
            steady_flow = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            cx = pick_center();
            cy = pick_center();
            if (kind < 10) begin
                // noise
                repeat ($urandom_range(1, 4))
                    send_request(t_op'($urandom_range(0, 1)), ADC_W'($urandom),
                                 ADC_W'($urandom));
            end else if (kind < 20) begin
                // point cut off by a clear
                repeat ($urandom_range(1, SAMPLES - 1))
                    send_request(OP_SAMPLE, jitter(cx, 40), jitter(cy, 40));
                send_request(OP_CLEAR, ADC_W'($urandom), ADC_W'($urandom));
            end else begin
                if (kind < 35) begin
                    // deviation right at or one step past the limit
                    odd = $urandom_range(0, SAMPLES - 1);
                    for (int i = 0; i < SAMPLES; i++) begin
                        if (i == odd)
                            send_request(OP_SAMPLE, edge_sample(cx, lim), edge_sample(cy, lim));
                        else
                            send_request(OP_SAMPLE, ADC_W'(cx), ADC_W'(cy));
                    end
                end else begin
                    sx = pick_spread(lim);
                    sy = ($urandom_range(0, 1) == 1) ? sx : pick_spread(lim);
                    repeat (SAMPLES)
                        send_request(OP_SAMPLE, jitter(cx, sx), jitter(cy, sy));
                end
                // late samples, then usually a clear
                repeat ($urandom_range(0, 3))
                    send_request(OP_SAMPLE, ADC_W'($urandom), ADC_W'($urandom));
                if ($urandom_range(0, 4) != 0)
                    send_request(OP_CLEAR, ADC_W'($urandom), ADC_W'($urandom));
            end
        end
        steady_flow = 1'b0;
    endtask

    // receiver holds off while requests keep coming, so the block fills up
    task automatic test_backpressure();
        int cx;
        int cy;
        steady_flow  = 1'b1;
        hold_off_req = 1'b1;
        repeat (2) begin
            cx = pick_center();
            cy = pick_center();
            repeat (SAMPLES)
                send_request(OP_SAMPLE, jitter(cx, 5), jitter(cy, 5));
            send_request(OP_CLEAR, '0, '0);
        end
        steady_flow = 1'b0;
    endtask

    // result side ready pattern
    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                stall = steady_flow ? 0 : idle_len();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_point_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d", $time,
                         m_axis_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[ADC_W-1:0] != want.mean_x) begin
                    $display("%0t: mean_x expected %0d actual %0d", $time, want.mean_x,
                             m_axis_tdata[ADC_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[2*ADC_W-1:ADC_W] != want.mean_y) begin
                    $display("%0t: mean_y expected %0d actual %0d", $time, want.mean_y,
                             m_axis_tdata[2*ADC_W-1:ADC_W]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin : test_sequence
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SAMPLE;
        pt_limit = ADC_W'(LIMIT_RST);
        clear_point();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_limit_edge();
        test_field_extremes();
        test_random_points('0, 180);
        test_random_points(ADC_W'(ADC_MAX), 180);
        test_backpressure();
        test_random_points(12'd1, 160);
        test_random_points(ADC_W'($urandom_range(2, 300)), 200);
        test_random_points(ADC_W'(LIMIT_RST), 180);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
